// ----- rtl/crcdf_pkg.sv -----
`timescale 1ns / 1ps

package crcdf_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_VERSION   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_EXEMPT    = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // reset values of the registers
  localparam logic [7:0]  MAGIC_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  MAGIC_SECOND_RST = 8'h55;
  localparam logic [7:0]  EXP_VERSION_RST  = 8'h01;
  localparam logic [15:0] CRC_SEED_RST     = 16'hFFFF;
  localparam logic [7:0]  GAP_EXEMPT_RST   = 8'h00;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // event codes on the result channel
  typedef enum logic [1:0] {
    EV_PAYLOAD     = 2'd0,
    EV_FRAME_GOOD  = 2'd1,
    EV_BAD_CRC     = 2'd2,
    EV_BAD_VERSION = 2'd3
  } event_kind_t;

  // one result word
  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        payload_last;
    logic [7:0]  frame_seq;
    logic [7:0]  frame_type;
    logic [7:0]  frame_len;
    logic        seq_gap;
    logic [7:0]  gap_amount;
    logic [15:0] crc_received;
    logic [15:0] crc_computed;
  } result_t;

  // crc-16-ccitt, msb first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- rtl/crcdf_if.sv -----
`timescale 1ns / 1ps

// received byte channel
interface crcdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// result channel
interface crcdf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic        payload_last;
  logic [7:0]  frame_seq;
  logic [7:0]  frame_type;
  logic [7:0]  frame_len;
  logic        seq_gap;
  logic [7:0]  gap_amount;
  logic [15:0] crc_received;
  logic [15:0] crc_computed;
  modport source (output valid, output event_kind, output payload_byte, output payload_index,
                  output payload_last, output frame_seq, output frame_type, output frame_len,
                  output seq_gap, output gap_amount, output crc_received,
                  output crc_computed, input ready);
  modport sink (input valid, input event_kind, input payload_byte, input payload_index,
                input payload_last, input frame_seq, input frame_type, input frame_len,
                input seq_gap, input gap_amount, input crc_received,
                input crc_computed, output ready);
endinterface

// ----- rtl/crc16_frame_deframer.sv -----
`timescale 1ns / 1ps

// channel   direction  contents
// in_ch     sink       rx_byte, one received byte per word
// out_ch    source     event_kind, payload and header fields, crc pair
// cfg_*     write      magic bytes, version, crc seed, exempt type
//
// one byte is taken every cycle while in_ch.ready is high; a result word
// goes to the output register, or to its skid stage while that one is held.
// the parser and the eight-bit crc update sit between the accepted byte and
// those registers. in_ch.ready falls only when both hold words. reset is
// synchronous and puts the parser back into the magic hunt with its state and config registers at defaults.

module crc16_frame_deframer import crcdf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  crcdf_in_if.sink              in_ch,
  crcdf_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [8:0] {
    PH_MAGIC0  = 9'b000000001,
    PH_MAGIC1  = 9'b000000010,
    PH_VER     = 9'b000000100,
    PH_SEQ     = 9'b000001000,
    PH_TYPE    = 9'b000010000,
    PH_LEN     = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CRC_LO  = 9'b010000000,
    PH_CRC_HI  = 9'b100000000
  } phase_t;

  logic [7:0]  magic_first_r, magic_second_r, exp_version_r, gap_exempt_r;
  logic [15:0] crc_seed_r;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_seq_r, held_seq_nxt;
  logic [7:0]  held_type_r, held_type_nxt;
  logic [7:0]  held_len_r, held_len_nxt;
  logic [7:0]  pay_cnt_r, pay_cnt_nxt;
  logic [15:0] run_crc_r, run_crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic        seq_valid_r, seq_valid_nxt;
  logic [7:0]  last_seq_r, last_seq_nxt;

  logic        accept;
  logic        res_valid;
  result_t     res;
  logic        buf_ready;
  logic [7:0]  b;
  logic [15:0] crc_in, crc_upd;
  logic [15:0] rx_crc;
  logic [7:0]  expect_seq;
  logic        is_last;

  assign in_ch.ready = buf_ready;
  assign accept      = in_ch.valid && buf_ready;
  assign b           = in_ch.rx_byte;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_first_r  <= MAGIC_FIRST_RST;
      magic_second_r <= MAGIC_SECOND_RST;
      exp_version_r  <= EXP_VERSION_RST;
      crc_seed_r     <= CRC_SEED_RST;
      gap_exempt_r   <= GAP_EXEMPT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAGIC_FIRST:  magic_first_r  <= cfg_data[7:0];
        CFG_MAGIC_SECOND: magic_second_r <= cfg_data[7:0];
        CFG_EXP_VERSION:  exp_version_r  <= cfg_data[7:0];
        CFG_CRC_SEED:     crc_seed_r     <= cfg_data;
        CFG_GAP_EXEMPT:   gap_exempt_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // crc update, seeded on the version byte
  assign crc_in     = (phase_r == PH_VER) ? crc_seed_r : run_crc_r;
  assign crc_upd    = crc_byte(crc_in, b);
  assign rx_crc     = {b, crc_lo_r};
  assign expect_seq = last_seq_r + 8'd1;
  assign is_last    = ({1'b0, pay_cnt_r} + 9'd1) >= {1'b0, held_len_r};

  // frame parser
  always_comb begin
    phase_nxt     = phase_r;
    held_seq_nxt  = held_seq_r;
    held_type_nxt = held_type_r;
    held_len_nxt  = held_len_r;
    pay_cnt_nxt   = pay_cnt_r;
    run_crc_nxt   = run_crc_r;
    crc_lo_nxt    = crc_lo_r;
    seq_valid_nxt = seq_valid_r;
    last_seq_nxt  = last_seq_r;
    res_valid     = 1'b0;
    res           = '0;
    case (phase_r)
      PH_MAGIC1: begin
        if (b == magic_second_r) phase_nxt = PH_VER;
        else if (b == magic_first_r) phase_nxt = PH_MAGIC1;
        else phase_nxt = PH_MAGIC0;
      end
      PH_VER: begin
        if (b != exp_version_r) begin
          phase_nxt      = PH_MAGIC0;
          res_valid      = 1'b1;
          res.event_kind = EV_BAD_VERSION;
        end else begin
          run_crc_nxt = crc_upd;
          phase_nxt   = PH_SEQ;
        end
      end
      PH_SEQ: begin
        held_seq_nxt = b;
        run_crc_nxt  = crc_upd;
        phase_nxt    = PH_TYPE;
      end
      PH_TYPE: begin
        held_type_nxt = b;
        run_crc_nxt   = crc_upd;
        phase_nxt     = PH_LEN;
      end
      PH_LEN: begin
        held_len_nxt = b;
        run_crc_nxt  = crc_upd;
        pay_cnt_nxt  = 8'd0;
        phase_nxt    = (b == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        run_crc_nxt       = crc_upd;
        res_valid         = 1'b1;
        res.event_kind    = EV_PAYLOAD;
        res.payload_byte  = b;
        res.payload_index = pay_cnt_r;
        res.payload_last  = is_last;
        res.frame_seq     = held_seq_r;
        res.frame_type    = held_type_r;
        res.frame_len     = held_len_r;
        pay_cnt_nxt       = pay_cnt_r + 8'd1;
        if (is_last) phase_nxt = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        crc_lo_nxt = b;
        phase_nxt  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        res_valid        = 1'b1;
        res.frame_seq    = held_seq_r;
        res.frame_type   = held_type_r;
        res.frame_len    = held_len_r;
        res.crc_received = rx_crc;
        res.crc_computed = run_crc_r;
        if (rx_crc == run_crc_r) begin
          res.event_kind = EV_FRAME_GOOD;
          // sequence tracking on good frames of tracked types
          if (held_type_r != gap_exempt_r) begin
            if (seq_valid_r && held_seq_r != expect_seq) begin
              res.seq_gap    = 1'b1;
              res.gap_amount = held_seq_r - expect_seq;
            end
            last_seq_nxt  = held_seq_r;
            seq_valid_nxt = 1'b1;
          end
        end else begin
          res.event_kind = EV_BAD_CRC;
        end
        phase_nxt   = PH_MAGIC0;
        pay_cnt_nxt = 8'd0;
      end
      default: begin
        phase_nxt = (b == magic_first_r) ? PH_MAGIC1 : PH_MAGIC0;
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAGIC0;
      held_seq_r  <= 8'd0;
      held_type_r <= 8'd0;
      held_len_r  <= 8'd0;
      pay_cnt_r   <= 8'd0;
      run_crc_r   <= CRC_SEED_RST;
      crc_lo_r    <= 8'd0;
      seq_valid_r <= 1'b0;
      last_seq_r  <= 8'd0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      held_seq_r  <= held_seq_nxt;
      held_type_r <= held_type_nxt;
      held_len_r  <= held_len_nxt;
      pay_cnt_r   <= pay_cnt_nxt;
      run_crc_r   <= run_crc_nxt;
      crc_lo_r    <= crc_lo_nxt;
      seq_valid_r <= seq_valid_nxt;
      last_seq_r  <= last_seq_nxt;
    end
  end

  // result register with skid stage
  crcdf_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (accept && res_valid),
    .wr_ready (buf_ready),
    .wr_data  (res),
    .out_ch   (out_ch)
  );

endmodule

// ----- rtl/crcdf_out_buf.sv -----
`timescale 1ns / 1ps

module crcdf_out_buf import crcdf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  result_t    wr_data,
  crcdf_out_if.source out_ch
);

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    pop;

  // room as long as the skid stage is empty
  assign wr_ready = !skid_valid_r;
  assign pop      = out_valid_r && out_ch.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = wr_valid;
        out_data_nxt  = wr_data;
      end
    end else if (wr_valid && !skid_valid_r) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  // drive the result channel from the head register
  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_kind    = out_data_r.event_kind;
  assign out_ch.payload_byte  = out_data_r.payload_byte;
  assign out_ch.payload_index = out_data_r.payload_index;
  assign out_ch.payload_last  = out_data_r.payload_last;
  assign out_ch.frame_seq     = out_data_r.frame_seq;
  assign out_ch.frame_type    = out_data_r.frame_type;
  assign out_ch.frame_len     = out_data_r.frame_len;
  assign out_ch.seq_gap       = out_data_r.seq_gap;
  assign out_ch.gap_amount    = out_data_r.gap_amount;
  assign out_ch.crc_received  = out_data_r.crc_received;
  assign out_ch.crc_computed  = out_data_r.crc_computed;

endmodule

// ----- tb/tb_crc16_frame_deframer.sv -----
`timescale 1ns / 1ps

module tb_crc16_frame_deframer;
  import crcdf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  // parser phases of the predictor
  typedef enum logic [3:0] {
    PH_HUNT,
    PH_SECOND,
    PH_VERSION,
    PH_SEQ,
    PH_TYPE,
    PH_LEN,
    PH_PAYLOAD,
    PH_CRC_LO,
    PH_CRC_HI
  } parse_phase_t;

  // frame parser predictor and queue of expected event words
  class deframe_scoreboard;
    logic [7:0]   magic_a, magic_b, version_req, exempt_type;
    logic [15:0]  seed;
    parse_phase_t phase;
    logic [7:0]   seq_hold, type_hold, len_hold, count, crc_lo;
    logic [15:0]  crc;
    bit           seq_seen;
    logic [7:0]   last_good_seq;
    result_t      pending[$];
    int unsigned  errors;

    function new();
      magic_a       = MAGIC_FIRST_RST;
      magic_b       = MAGIC_SECOND_RST;
      version_req   = EXP_VERSION_RST;
      seed          = CRC_SEED_RST;
      exempt_type   = GAP_EXEMPT_RST;
      phase         = PH_HUNT;
      seq_hold      = '0;
      type_hold     = '0;
      len_hold      = '0;
      count         = '0;
      crc_lo        = '0;
      crc           = 16'hFFFF;
      seq_seen      = 1'b0;
      last_good_seq = '0;
      errors        = 0;
    endfunction

    // crc-16-ccitt msb first over one byte
    static function logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
      logic [15:0] c;
      c = crc_in ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
        if (c[15]) c = {c[14:0], 1'b0} ^ 16'h1021;
        else c = {c[14:0], 1'b0};
      end
      return c;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MAGIC_FIRST:  magic_a = val[7:0];
        CFG_MAGIC_SECOND: magic_b = val[7:0];
        CFG_EXP_VERSION:  version_req = val[7:0];
        CFG_CRC_SEED:     seed = val;
        CFG_GAP_EXEMPT:   exempt_type = val[7:0];
        default: ;
      endcase
    endfunction

    // one accepted byte, queue the event word it causes
    function void note_input(input logic [7:0] b);
      result_t    r;
      bit         emit;
      bit         last;
      logic [15:0] rx_crc;
      logic [7:0] next_seq;
      r = '0;
      emit = 1'b0;
      case (phase)
        PH_SECOND: begin
          if (b == magic_b) phase = PH_VERSION;
          else if (b == magic_a) phase = PH_SECOND;
          else phase = PH_HUNT;
        end
        PH_VERSION: begin
          if (b != version_req) begin
            phase = PH_HUNT;
            r.event_kind = EV_BAD_VERSION;
            emit = 1'b1;
          end else begin
            crc = crc_step(seed, b);
            phase = PH_SEQ;
          end
        end
        PH_SEQ: begin
          seq_hold = b;
          crc = crc_step(crc, b);
          phase = PH_TYPE;
        end
        PH_TYPE: begin
          type_hold = b;
          crc = crc_step(crc, b);
          phase = PH_LEN;
        end
        PH_LEN: begin
          len_hold = b;
          crc = crc_step(crc, b);
          count = '0;
          phase = (b == 8'h00) ? PH_CRC_LO : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          last = (int'(count) + 1 >= int'(len_hold));
          crc = crc_step(crc, b);
          r.event_kind    = EV_PAYLOAD;
          r.payload_byte  = b;
          r.payload_index = count;
          r.payload_last  = last;
          r.frame_seq     = seq_hold;
          r.frame_type    = type_hold;
          r.frame_len     = len_hold;
          emit = 1'b1;
          count = count + 8'd1;
          if (last) phase = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          crc_lo = b;
          phase = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          rx_crc = {b, crc_lo};
          r.frame_seq    = seq_hold;
          r.frame_type   = type_hold;
          r.frame_len    = len_hold;
          r.crc_received = rx_crc;
          r.crc_computed = crc;
          if (rx_crc == crc) begin
            r.event_kind = EV_FRAME_GOOD;
            // sequence tracking skips the exempt type
            if (type_hold != exempt_type) begin
              next_seq = last_good_seq + 8'd1;
              if (seq_seen && seq_hold != next_seq) begin
                r.seq_gap    = 1'b1;
                r.gap_amount = seq_hold - next_seq;
              end
              last_good_seq = seq_hold;
              seq_seen = 1'b1;
            end
          end else begin
            r.event_kind = EV_BAD_CRC;
          end
          emit = 1'b1;
          phase = PH_HUNT;
          count = '0;
        end
        default: begin
          phase = (b == magic_a) ? PH_SECOND : PH_HUNT;
        end
      endcase
      if (emit) pending.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // one accepted event word against the oldest expectation
    function void check_result(input result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("event word with none expected: event_kind %0d", got.event_kind);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("event_kind", want.event_kind, got.event_kind);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_index", want.payload_index, got.payload_index);
      compare_field("payload_last", want.payload_last, got.payload_last);
      compare_field("frame_seq", want.frame_seq, got.frame_seq);
      compare_field("frame_type", want.frame_type, got.frame_type);
      compare_field("frame_len", want.frame_len, got.frame_len);
      compare_field("seq_gap", want.seq_gap, got.seq_gap);
      compare_field("gap_amount", want.gap_amount, got.gap_amount);
      compare_field("crc_received", want.crc_received, got.crc_received);
      compare_field("crc_computed", want.crc_computed, got.crc_computed);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  crcdf_in_if  in_ch ();
  crcdf_out_if out_ch ();

  deframe_scoreboard sb = new();

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_req;
  int unsigned bytes_sent;
  int unsigned cycles;

  crc16_frame_deframer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // result side: check accepted words, then pick the next ready
  initial begin
    result_t     seen;
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        seen.event_kind    = out_ch.event_kind;
        seen.payload_byte  = out_ch.payload_byte;
        seen.payload_index = out_ch.payload_index;
        seen.payload_last  = out_ch.payload_last;
        seen.frame_seq     = out_ch.frame_seq;
        seen.frame_type    = out_ch.frame_type;
        seen.frame_len     = out_ch.frame_len;
        seen.seq_gap       = out_ch.seq_gap;
        seen.gap_amount    = out_ch.gap_amount;
        seen.crc_received  = out_ch.crc_received;
        seen.crc_computed  = out_ch.crc_computed;
        sb.check_result(seen);
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // offer one byte, with a possible random gap first, and wait for the handshake
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(b);
    bytes_sent++;
  endtask

  // whole frame with random payload, crc optionally spoilt
  task automatic send_frame(input logic [15:0] start_crc, input logic [7:0] ver,
                            input logic [7:0] sq, input logic [7:0] ty,
                            input logic [7:0] ln, input bit spoil);
    logic [15:0] c;
    logic [7:0]  pb;
    send_byte(sb.magic_a);
    send_byte(sb.magic_b);
    send_byte(ver);
    c = deframe_scoreboard::crc_step(start_crc, ver);
    c = deframe_scoreboard::crc_step(c, sq);
    send_byte(sq);
    c = deframe_scoreboard::crc_step(c, ty);
    send_byte(ty);
    c = deframe_scoreboard::crc_step(c, ln);
    send_byte(ln);
    for (int i = 0; i < int'(ln); i++) begin
      pb = 8'($urandom);
      c = deframe_scoreboard::crc_step(c, pb);
      send_byte(pb);
    end
    if (spoil) c = c ^ 16'($urandom_range(65535, 1));
    send_byte(c[7:0]);
    send_byte(c[15:8]);
  endtask

  // stop offering until every expected word has come, then let the pipe settle
  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly well formed frames, some bad version, resync and noise
  task automatic run_random(input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  sq, ty, ln;
    stop_at = bytes_sent + quota;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        sq = ($urandom_range(3) == 0) ? 8'($urandom) : sb.last_good_seq + 8'd1;
        ty = ($urandom_range(4) == 0) ? sb.exempt_type : 8'($urandom);
        if ($urandom_range(59) == 0) ln = 8'($urandom_range(255, 128));
        else ln = 8'($urandom_range(8));
        if (pick >= 70) send_byte(sb.magic_a);
        send_frame(sb.seed, sb.version_req, sq, ty, ln, $urandom_range(5) == 0);
      end else if (pick < 88) begin
        send_byte(sb.magic_a);
        send_byte(sb.magic_b);
        send_byte(sb.version_req ^ 8'($urandom_range(255, 1)));
      end else begin
        repeat ($urandom_range(5, 1)) begin
          if ($urandom_range(3) == 0) send_byte(sb.magic_a);
          else send_byte(8'($urandom));
        end
      end
    end
  endtask

  // main sequence
  initial begin
    logic [15:0] mid_crc;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    hold_req      = 0;
    bytes_sent    = 0;
    src_idle_pct  = 14;
    sink_idle_pct = 82;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_reg(CFG_MAGIC_FIRST, 16'(MAGIC_FIRST_RST));
    set_reg(CFG_MAGIC_SECOND, 16'(MAGIC_SECOND_RST));
    set_reg(CFG_EXP_VERSION, 16'(EXP_VERSION_RST));
    set_reg(CFG_CRC_SEED, CRC_SEED_RST);
    set_reg(CFG_GAP_EXEMPT, 16'(GAP_EXEMPT_RST));

    // noise, repeated first magic, bad version equal to the first magic,
    // then a second magic that must not count after it
    send_byte(8'h00);
    send_byte(MAGIC_FIRST_RST);
    send_byte(MAGIC_FIRST_RST);
    send_byte(MAGIC_SECOND_RST);
    send_byte(MAGIC_FIRST_RST);
    send_byte(MAGIC_SECOND_RST);
    // first tracked frame, empty payload
    send_frame(sb.seed, sb.version_req, 8'hFF, 8'h07, 8'h00, 1'b0);
    // one payload byte, sequence skips one
    send_frame(sb.seed, sb.version_req, 8'h01, 8'hFF, 8'h01, 1'b0);
    // exempt type is not tracked
    send_frame(sb.seed, sb.version_req, 8'h40, sb.exempt_type, 8'h00, 1'b0);
    // seed written after the version byte only affects later frames
    send_byte(sb.magic_a);
    send_byte(sb.magic_b);
    send_byte(sb.version_req);
    send_byte(8'h02);
    mid_crc = deframe_scoreboard::crc_step(sb.seed, sb.version_req);
    mid_crc = deframe_scoreboard::crc_step(mid_crc, 8'h02);
    mid_crc = deframe_scoreboard::crc_step(mid_crc, 8'h07);
    mid_crc = deframe_scoreboard::crc_step(mid_crc, 8'h00);
    pause_until_drained();
    set_reg(CFG_CRC_SEED, 16'h0000);
    send_byte(8'h07);
    send_byte(8'h00);
    send_byte(mid_crc[7:0]);
    send_byte(mid_crc[15:8]);

    run_random(240);
    pause_until_drained();

    // extreme settings, receiver mostly ready
    set_reg(CFG_MAGIC_FIRST, 16'h0000);
    set_reg(CFG_MAGIC_SECOND, 16'h00FF);
    set_reg(CFG_EXP_VERSION, 16'h00FF);
    set_reg(CFG_CRC_SEED, 16'h0000);
    set_reg(CFG_GAP_EXEMPT, 16'h00FF);
    src_idle_pct  = 82;
    sink_idle_pct = 14;
    run_random(240);
    pause_until_drained();

    // equal magic bytes, random seed and exempt type, no idling
    set_reg(CFG_MAGIC_FIRST, 16'h00FF);
    set_reg(CFG_MAGIC_SECOND, 16'h00FF);
    set_reg(CFG_EXP_VERSION, 16'h0000);
    set_reg(CFG_CRC_SEED, 16'($urandom));
    set_reg(CFG_GAP_EXEMPT, 16'($urandom_range(255)));
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    // long receiver hold while a frame keeps coming
    hold_req = 300;
    send_frame(sb.seed, sb.version_req, sb.last_good_seq + 8'd1, 8'h11, 8'd40, 1'b0);
    pause_until_drained();
    // longest payload
    send_frame(sb.seed, sb.version_req, sb.last_good_seq + 8'd1, 8'h12, 8'd255, 1'b0);
    run_random(220);
    pause_until_drained();

    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/crcdf_pkg.sv
rtl/crcdf_if.sv
rtl/crcdf_out_buf.sv
rtl/crc16_frame_deframer.sv
tb/tb_crc16_frame_deframer.sv
